// ===== sv/irhf_pkg.sv =====
// irhf_pkg: shared types and constants for the ipv4 receive header filter
// item structs, frame record, configuration set, verdict and register codes
// no dependencies
package irhf_pkg;

  localparam logic [15:0] LINK_HDR_BYTES = 16'd14;
  localparam logic [15:0] MIN_IP_HDR     = 16'd20;
  localparam int          CFG_DATA_W     = 32;
  localparam int          CFG_INDEX_W    = 2;

  typedef enum logic [3:0] {
    VERDICT_DELIVER   = 4'd0,
    VERDICT_FRAGMENT  = 4'd1,
    VERDICT_ROUTE     = 4'd2,
    VERDICT_RUNT      = 4'd3,
    VERDICT_VERSION   = 4'd4,
    VERDICT_LENGTH    = 4'd5,
    VERDICT_CHECKSUM  = 4'd6,
    VERDICT_BCAST     = 4'd7,
    VERDICT_NOT_OURS  = 4'd8
  } verdict_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LOCAL_ADDRESS = 2'd0,
    CFG_SUBNET_MASK   = 2'd1,
    CFG_ZERO_HOST     = 2'd2,
    CFG_ROUTER_MODE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [5:0]  header_bytes;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic        to_local_address;
    logic        has_options;
  } out_item_t;

  typedef struct packed {
    logic [31:0] local_address;
    logic [31:0] subnet_mask;
    logic        zero_host_broadcast;
    logic        router_mode;
  } cfg_t;

  // header snapshot taken on the final byte of a frame
  typedef struct packed {
    logic [15:0] ip_count;
    logic [7:0]  version_ihl;
    logic [15:0] length_field;
    logic [15:0] flags_offset;
    logic [7:0]  proto_field;
    logic [31:0] src_field;
    logic [31:0] dst_field;
    logic [15:0] sum;
    logic        link_multicast;
  } frame_rec_t;

endpackage

// ===== sv/ipv4_receive_header_filter.sv =====
// ipv4_receive_header_filter: top level, configuration registers and the two stages
// depends on irhf_pkg, irhf_parse, irhf_judge
//
//  channel | ports                               | moves
//  --------+-------------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_item         | one frame byte with end mark
//  result  | out_valid, out_ready, out_item      | one verdict item per frame
//  config  | cfg_wr_en, cfg_index, cfg_wdata     | register write, no wait
//
// one byte item is taken every cycle unless a final byte waits for the frame record;
// a frame's result passes the input register, the frame record and the result register
// reset is synchronous on rst_n low and clears configuration and all frame state
// a stalled result holds the frame record, which in turn holds only a final byte;
// ordinary bytes keep flowing while a result waits
module ipv4_receive_header_filter
  import irhf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_item,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t       cfg_r;
  logic       rec_valid;
  frame_rec_t rec;
  logic       rec_take;

  // configuration bank; to be written only while the block is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LOCAL_ADDRESS: cfg_r.local_address       <= cfg_wdata;
        CFG_SUBNET_MASK:   cfg_r.subnet_mask         <= cfg_wdata;
        CFG_ZERO_HOST:     cfg_r.zero_host_broadcast <= cfg_wdata[0];
        CFG_ROUTER_MODE:   cfg_r.router_mode         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // byte stage: skips the link header, captures fields, sums the ip header
  irhf_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take)
  );

  // frame stage: checks, destination match and the result register
  irhf_judge u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_take  (rec_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ===== sv/irhf_parse.sv =====
// irhf_parse: input register, per-byte header capture and checksum, frame record
// depends on irhf_pkg
module irhf_parse
  import irhf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       rec_valid,
  output frame_rec_t rec,
  input  logic       rec_take
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        rec_valid_r;
  frame_rec_t  rec_r;
  frame_rec_t  rec_nxt;

  logic [15:0] byte_cnt_r,  byte_cnt_nxt;
  logic [15:0] sum_r,       sum_nxt;
  logic [7:0]  hold_r,      hold_nxt;
  logic        mcast_r,     mcast_nxt;
  logic [7:0]  vihl_r,      vihl_nxt;
  logic [15:0] len_r,       len_nxt;
  logic [15:0] frag_r,      frag_nxt;
  logic [7:0]  proto_r,     proto_nxt;
  logic [31:0] src_r,       src_nxt;
  logic [31:0] dst_r,       dst_nxt;

  logic        rec_ready;
  logic        step;
  logic        in_ip;
  logic [15:0] pos;
  logic [5:0]  hdr_nxt;
  logic [7:0]  b;
  logic [16:0] add1;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign rec_ready = !rec_valid_r || rec_take;
  assign step      = in_valid_r && (!in_item_r.frame_end || rec_ready);
  assign in_ready  = !in_valid_r || step;
  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

  assign b     = in_item_r.frame_byte;
  assign in_ip = (byte_cnt_r >= LINK_HDR_BYTES);
  assign pos   = byte_cnt_r - LINK_HDR_BYTES;

  // end-around-carry add of one 16-bit word
  assign add1  = {1'b0, sum_r} + {1'b0, hold_r, b};
  assign fold1 = {1'b0, add1[15:0]} + {16'd0, add1[16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    mcast_nxt = mcast_r;
    vihl_nxt  = vihl_r;
    len_nxt   = len_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    hold_nxt  = hold_r;
    sum_nxt   = sum_r;
    if (byte_cnt_r == 16'd0) begin
      mcast_nxt = b[0];
    end
    if (in_ip) begin
      case (pos)
        16'd0: vihl_nxt = b;
        16'd2: len_nxt = {b, len_r[7:0]};
        16'd3: len_nxt = {len_r[15:8], b};
        16'd6: frag_nxt = {b, frag_r[7:0]};
        16'd7: frag_nxt = {frag_r[15:8], b};
        16'd9: proto_nxt = b;
        16'd12, 16'd13, 16'd14, 16'd15: src_nxt = {src_r[23:0], b};
        16'd16, 16'd17, 16'd18, 16'd19: dst_nxt = {dst_r[23:0], b};
        default: ;
      endcase
    end
    // header length follows the version byte of this very step
    hdr_nxt = {vihl_nxt[3:0], 2'b00};
    if (in_ip && (pos < {10'd0, hdr_nxt})) begin
      if (!pos[0]) begin
        hold_nxt = b;
      end else begin
        sum_nxt = fold2;
      end
    end
    byte_cnt_nxt = (byte_cnt_r == 16'hFFFF) ? byte_cnt_r : byte_cnt_r + 16'd1;

    rec_nxt.ip_count       = (byte_cnt_nxt > LINK_HDR_BYTES) ?
                             byte_cnt_nxt - LINK_HDR_BYTES : 16'd0;
    rec_nxt.version_ihl    = vihl_nxt;
    rec_nxt.length_field   = len_nxt;
    rec_nxt.flags_offset   = frag_nxt;
    rec_nxt.proto_field    = proto_nxt;
    rec_nxt.src_field      = src_nxt;
    rec_nxt.dst_field      = dst_nxt;
    rec_nxt.sum            = sum_nxt;
    rec_nxt.link_multicast = mcast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      rec_valid_r <= 1'b0;
      byte_cnt_r  <= '0;
      sum_r       <= '0;
      hold_r      <= '0;
      mcast_r     <= 1'b0;
      vihl_r      <= '0;
      len_r       <= '0;
      frag_r      <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (rec_ready) begin
        rec_valid_r <= step && in_item_r.frame_end;
      end
      if (step) begin
        if (in_item_r.frame_end) begin
          byte_cnt_r <= '0;
          sum_r      <= '0;
          hold_r     <= '0;
          mcast_r    <= 1'b0;
          vihl_r     <= '0;
          len_r      <= '0;
          frag_r     <= '0;
          proto_r    <= '0;
          src_r      <= '0;
          dst_r      <= '0;
        end else begin
          byte_cnt_r <= byte_cnt_nxt;
          sum_r      <= sum_nxt;
          hold_r     <= hold_nxt;
          mcast_r    <= mcast_nxt;
          vihl_r     <= vihl_nxt;
          len_r      <= len_nxt;
          frag_r     <= frag_nxt;
          proto_r    <= proto_nxt;
          src_r      <= src_nxt;
          dst_r      <= dst_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (step && in_item_r.frame_end) begin
      rec_r <= rec_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_item_r.frame_end |=> byte_cnt_r == 16'd0 && sum_r == 16'd0)
    else $error("frame state not cleared after final byte");
  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rec_valid_r && !rec_take |=> rec_valid_r && $stable(rec_r))
    else $error("frame record lost while stalled");
  a_end_waits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && in_item_r.frame_end && !rec_ready |=> in_valid_r)
    else $error("final byte dropped while record slot busy");
`endif

endmodule

// ===== sv/irhf_judge.sv =====
// irhf_judge: verdict and address match on a frame record, result register
// depends on irhf_pkg
module irhf_judge
  import irhf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       rec_valid,
  input  frame_rec_t rec,
  output logic       rec_take,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  logic       out_valid_r;
  out_item_t  out_item_r;
  out_item_t  res_nxt;

  logic [5:0]  hdr;
  logic [15:0] n;
  logic [15:0] s;
  logic [31:0] cls_mask;
  logic        exact;
  logic        is_bcast;
  verdict_t    verdict;

  function automatic logic subnet_bcast(input logic [31:0] host, input logic [31:0] net,
                                        input logic [31:0] mask, input logic zero_ok);
    logic [31:0] hm;
    hm = ~mask;
    return ((host & mask) == (net & mask)) &&
           (((host & hm) == hm) || (zero_ok && ((host & hm) == 32'd0)));
  endfunction

  function automatic logic [31:0] class_mask(input logic [31:0] a);
    logic [31:0] m;
    if (!a[31]) begin
      m = 32'hFF00_0000;
    end else if (a[31:30] == 2'b10) begin
      m = 32'hFFFF_0000;
    end else if (a[31:29] == 3'b110) begin
      m = 32'hFFFF_FF00;
    end else begin
      m = 32'hFFFF_FFFF;
    end
    return m;
  endfunction

  assign rec_take  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign hdr      = {rec.version_ihl[3:0], 2'b00};
  assign n        = rec.ip_count;
  assign s        = (n < rec.length_field) ? n : rec.length_field;
  assign cls_mask = class_mask(rec.dst_field);
  assign exact    = (rec.dst_field == cfg.local_address);
  // exact local address wins over any broadcast form
  assign is_bcast = !exact && ((&rec.dst_field) ||
      subnet_bcast(rec.dst_field, cfg.local_address & cfg.subnet_mask, cfg.subnet_mask,
                   cfg.zero_host_broadcast) ||
      subnet_bcast(rec.dst_field, cfg.local_address & cls_mask, cls_mask,
                   cfg.zero_host_broadcast));

  always_comb begin
    if (n < MIN_IP_HDR) begin
      verdict = VERDICT_RUNT;
    end else if ((s < MIN_IP_HDR) || (s < {10'd0, hdr})) begin
      verdict = VERDICT_LENGTH;
    end else if (rec.version_ihl[7:4] != 4'd4) begin
      verdict = VERDICT_VERSION;
    end else if (rec.length_field > n) begin
      verdict = VERDICT_LENGTH;
    end else if (rec.sum != 16'hFFFF) begin
      verdict = VERDICT_CHECKSUM;
    end else if (rec.link_multicast && !is_bcast) begin
      verdict = VERDICT_BCAST;
    end else if (!exact && !is_bcast) begin
      verdict = cfg.router_mode ? VERDICT_ROUTE : VERDICT_NOT_OURS;
    end else if (rec.flags_offset[13:0] != 14'd0) begin
      verdict = VERDICT_FRAGMENT;
    end else begin
      verdict = VERDICT_DELIVER;
    end
    res_nxt.verdict             = verdict;
    res_nxt.header_bytes        = hdr;
    res_nxt.total_length        = rec.length_field;
    res_nxt.protocol_number     = rec.proto_field;
    res_nxt.source_address      = rec.src_field;
    res_nxt.destination_address = rec.dst_field;
    res_nxt.to_local_address    = exact;
    res_nxt.has_options         = (hdr > MIN_IP_HDR[5:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rec_take) begin
      out_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_take) begin
      out_item_r <= res_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_route_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.verdict == VERDICT_ROUTE |-> cfg.router_mode)
    else $error("route verdict outside router mode");
  a_drop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.verdict == VERDICT_NOT_OURS |-> !cfg.router_mode)
    else $error("not-ours verdict in router mode");
  a_deliver_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.verdict == VERDICT_DELIVER |->
      out_item_r.total_length >= MIN_IP_HDR)
    else $error("delivered packet shorter than a minimal header");
`endif

endmodule

// ===== dv/ipv4_receive_header_filter_test.sv =====
// ipv4_receive_header_filter_test: self-checking bench for the ipv4 receive header filter
// builds ethernet frames byte by byte, predicts each per-frame verdict and checks it
// depends on irhf_pkg and ipv4_receive_header_filter
module ipv4_receive_header_filter_test;
  import irhf_pkg::*;

  // how a destination address relates to this interface
  typedef enum logic [1:0] {
    DEST_NONE,
    DEST_LOCAL,
    DEST_BCAST
  } dest_kind_t;

  // recipe for one frame; the link header and unlisted header bytes are random
  typedef struct packed {
    logic        noise;     // whole frame is random bytes, cut bytes long
    logic        mcast;     // multicast bit of the link destination
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] flags;     // flags and fragment offset word
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    int          payload;   // bytes after the header, counted in total length
    int          extra;     // trailing bytes past total length
    int          len_adj;   // added to the correct total length
    int          cut;       // frame cut to this many bytes, -1 keeps it whole
    logic        good_sum;  // header checksum correct, else off by one bit
  } frame_spec_t;

  typedef struct packed {
    int          cfg_set;   // 0 keeps reset values, 1 uses the home network
    frame_spec_t f;
    logic        pinned;    // verdict below is typed in, not predicted
    verdict_t    verdict;
  } directed_row_t;

  localparam cfg_t HOME_NET = '{32'hC0A80105, 32'hFFFFFF00, 1'b1, 1'b1};
  localparam int NUM_ROWS = 23;

  // directed frames, one row each
  localparam directed_row_t STEPS [NUM_ROWS] = '{
    // short frames under reset configuration: no ip header at all, then one byte short
    '{0, '{0, 1, 4, 5, 0, 17, 32'h0A000002, 0, 0, 0, 0, 1, 1}, 1, VERDICT_RUNT},
    '{0, '{0, 0, 4, 5, 0, 17, 32'h0A000002, 0, 0, 0, 0, 33, 1}, 1, VERDICT_RUNT},
    // local address is zero after reset, so a zero destination is ours
    '{0, '{0, 0, 4, 5, 0, 0, 0, 0, 0, 0, 0, -1, 1}, 1, VERDICT_DELIVER},
    '{0, '{0, 1, 4, 5, 0, 6, 32'h0A000002, 32'hFFFFFFFF, 8, 0, 0, -1, 1}, 1, VERDICT_DELIVER},
    '{0, '{0, 0, 6, 5, 0, 6, 32'h0A000002, 0, 4, 0, 0, -1, 1}, 1, VERDICT_VERSION},
    // total length one past the data, then below the minimum header
    '{0, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 0, 0, 0, 1, -1, 1}, 1, VERDICT_LENGTH},
    '{0, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 0, 0, 0, -1, -1, 1}, 1, VERDICT_LENGTH},
    // total length shorter than a 60-byte header
    '{0, '{0, 0, 4, 15, 0, 6, 32'h0A000002, 0, 0, 0, -20, -1, 1}, 1, VERDICT_LENGTH},
    // zero ihl sums nothing
    '{0, '{0, 0, 4, 0, 0, 6, 32'h0A000002, 0, 2, 0, 0, -1, 1}, 1, VERDICT_CHECKSUM},
    '{0, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 0, 2, 0, 0, -1, 0}, 1, VERDICT_CHECKSUM},
    // link multicast to a foreign address, then to the exact local address, then a plain foreign address
    '{0, '{0, 1, 4, 5, 0, 6, 32'h0A000002, 32'h0A000001, 0, 0, 0, -1, 1}, 1, VERDICT_BCAST},
    '{0, '{0, 1, 4, 5, 0, 6, 32'h0A000002, 0, 0, 0, 0, -1, 1}, 1, VERDICT_BCAST},
    '{0, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 32'h0A000001, 0, 0, 0, -1, 1}, 1,
      VERDICT_NOT_OURS},
    // more fragments, offset only, dont-fragment only
    '{0, '{0, 0, 4, 5, 16'h2000, 6, 32'h0A000002, 0, 0, 0, 0, -1, 1}, 1, VERDICT_FRAGMENT},
    '{0, '{0, 0, 4, 5, 16'h1FFF, 6, 32'h0A000002, 32'hFFFFFFFF, 0, 0, 0, -1, 1}, 1,
      VERDICT_FRAGMENT},
    '{0, '{0, 0, 4, 5, 16'h4000, 6, 32'h0A000002, 0, 0, 0, 0, -1, 1}, 1, VERDICT_DELIVER},
    // home network, router on, zero host part accepted
    '{1, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 32'h08080808, 0, 0, 0, -1, 1}, 1, VERDICT_ROUTE},
    '{1, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 32'hC0A801FF, 0, 0, 0, -1, 1}, 1, VERDICT_DELIVER},
    '{1, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 32'hC0A80100, 0, 0, 0, -1, 1}, 1, VERDICT_DELIVER},
    // full options, trailing bytes, all-ones fields
    '{1, '{0, 0, 4, 15, 0, 6, 32'h0A000002, 32'hC0A80105, 10, 0, 0, -1, 1}, 0, VERDICT_DELIVER},
    '{1, '{0, 0, 4, 5, 0, 6, 32'h0A000002, 32'hC0A80105, 6, 40, 0, -1, 1}, 0, VERDICT_DELIVER},
    '{1, '{0, 1, 4, 15, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, -1, 1}, 0,
      VERDICT_DELIVER},
    // cut inside the options
    '{1, '{0, 0, 4, 10, 0, 6, 32'h0A000002, 32'hC0A80105, 0, 0, 0, 44, 1}, 0, VERDICT_DELIVER}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  // predictor copy of the registers and of the per-frame state
  cfg_t        model_cfg;
  logic [15:0] seen_count;
  logic [16:0] csum;
  logic [7:0]  hi_hold;
  logic        mcast_seen;
  logic [7:0]  ver_ihl;
  logic [15:0] len_f;
  logic [15:0] frag_f;
  logic [7:0]  proto_f;
  logic [31:0] src_f;
  logic [31:0] dst_f;

  out_item_t   pending_verdicts [$];
  logic [7:0]  frame_bytes [$];
  logic        pin_next;
  verdict_t    pin_verdict;
  logic        out_burst;
  int          mismatches;

  ipv4_receive_header_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // end-around-carry add of one 16-bit word
  function automatic logic [16:0] ones_add(logic [16:0] acc, logic [15:0] w);
    logic [16:0] s;
    s = acc + w;
    s = s[15:0] + s[16];
    s = s[15:0] + s[16];
    return s;
  endfunction

  function automatic logic [31:0] class_mask(logic [31:0] a);
    if (a[31] == 1'b0) return 32'hFF000000;
    if (a[31:30] == 2'b10) return 32'hFFFF0000;
    if (a[31:29] == 3'b110) return 32'hFFFFFF00;
    return 32'hFFFFFFFF;
  endfunction

  // network part matches and host part is all ones (or all zeros when allowed)
  function automatic logic host_bcast(logic [31:0] a, logic [31:0] net, logic [31:0] mask);
    logic [31:0] hm;
    hm = ~mask;
    if ((a & mask) != (net & mask)) return 1'b0;
    if ((a & hm) == hm) return 1'b1;
    if (model_cfg.zero_host_broadcast && (a & hm) == 32'h0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic dest_kind_t classify_dest(logic [31:0] a);
    logic [31:0] own;
    logic [31:0] cm;
    own = model_cfg.local_address;
    cm = class_mask(a);
    if (a == own) return DEST_LOCAL;
    if (a == 32'hFFFFFFFF) return DEST_BCAST;
    if (host_bcast(a, own & model_cfg.subnet_mask, model_cfg.subnet_mask)) return DEST_BCAST;
    if (host_bcast(a, own & cm, cm)) return DEST_BCAST;
    return DEST_NONE;
  endfunction

  // verdict order: runt, length, version, length, checksum, address checks, fragment
  function automatic verdict_t judge_frame();
    int hb;
    int n;
    int lf;
    int s;
    dest_kind_t m;
    hb = int'(ver_ihl[3:0]) * 4;
    n = (seen_count > LINK_HDR_BYTES) ? int'(seen_count) - 14 : 0;
    lf = int'(len_f);
    s = (n < lf) ? n : lf;
    m = classify_dest(dst_f);
    if (n < 20) return VERDICT_RUNT;
    if (s < 20 || s < hb) return VERDICT_LENGTH;
    if (ver_ihl[7:4] != 4'd4) return VERDICT_VERSION;
    if (lf > n) return VERDICT_LENGTH;
    if (csum != 17'h0FFFF) return VERDICT_CHECKSUM;
    if (mcast_seen && m != DEST_BCAST) return VERDICT_BCAST;
    if (m == DEST_NONE) return model_cfg.router_mode ? VERDICT_ROUTE : VERDICT_NOT_OURS;
    if (frag_f[13:0] != 14'h0) return VERDICT_FRAGMENT;
    return VERDICT_DELIVER;
  endfunction

  task automatic clear_frame_state();
    seen_count = '0;
    csum = '0;
    hi_hold = '0;
    mcast_seen = 1'b0;
    ver_ihl = '0;
    len_f = '0;
    frag_f = '0;
    proto_f = '0;
    src_f = '0;
    dst_f = '0;
  endtask

  // advance the predicted state by one accepted byte; the final byte yields a verdict
  task automatic absorb_byte(in_item_t it);
    int pos;
    int hb;
    logic [7:0] b;
    out_item_t o;
    b = it.frame_byte;
    if (seen_count == 16'd0) mcast_seen = b[0];
    if (seen_count >= LINK_HDR_BYTES) begin
      pos = int'(seen_count) - 14;
      case (pos)
        0: ver_ihl = b;
        2: len_f[15:8] = b;
        3: len_f[7:0] = b;
        6: frag_f[15:8] = b;
        7: frag_f[7:0] = b;
        9: proto_f = b;
        12, 13, 14, 15: src_f = {src_f[23:0], b};
        16, 17, 18, 19: dst_f = {dst_f[23:0], b};
        default: ;
      endcase
      hb = int'(ver_ihl[3:0]) * 4;
      if (pos < hb) begin
        if (pos[0] == 1'b0) hi_hold = b;
        else csum = ones_add(csum, {hi_hold, b});
      end
    end
    if (seen_count != 16'hFFFF) seen_count = seen_count + 16'd1;
    if (it.frame_end) begin
      hb = int'(ver_ihl[3:0]) * 4;
      o.verdict = pin_next ? pin_verdict : judge_frame();
      o.header_bytes = 6'(hb);
      o.total_length = len_f;
      o.protocol_number = proto_f;
      o.source_address = src_f;
      o.destination_address = dst_f;
      o.to_local_address = (dst_f == model_cfg.local_address);
      o.has_options = (hb > 20);
      pending_verdicts.push_back(o);
      pin_next = 1'b0;
      clear_frame_state();
    end
  endtask

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // turn a recipe into frame bytes, link header first
  task automatic build_frame(frame_spec_t f);
    logic [7:0]  ip [60];
    logic [7:0]  b;
    logic [15:0] lf;
    logic [15:0] cs;
    logic [16:0] acc;
    int hlen;
    int sum_len;
    frame_bytes.delete();
    if (f.noise) begin
      repeat (f.cut) frame_bytes.push_back(8'($urandom));
      return;
    end
    b = 8'($urandom);
    b[0] = f.mcast;
    frame_bytes.push_back(b);
    repeat (13) frame_bytes.push_back(8'($urandom));
    sum_len = int'(f.ihl) * 4;
    hlen = (sum_len < 20) ? 20 : sum_len;
    lf = 16'(hlen + f.payload + f.len_adj);
    for (int k = 0; k < hlen; k++) ip[k] = 8'($urandom);
    ip[0] = {f.ver, f.ihl};
    ip[2] = lf[15:8];
    ip[3] = lf[7:0];
    ip[6] = f.flags[15:8];
    ip[7] = f.flags[7:0];
    ip[9] = f.proto;
    ip[10] = 8'h00;
    ip[11] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      ip[12 + k] = f.src[31 - 8*k -: 8];
      ip[16 + k] = f.dst[31 - 8*k -: 8];
    end
    // checksum field only counts when the summed header reaches it
    if (sum_len >= 12) begin
      acc = '0;
      for (int k = 0; k < sum_len; k += 2) acc = ones_add(acc, {ip[k], ip[k+1]});
      cs = ~acc[15:0];
      if (!f.good_sum) cs[0] = ~cs[0];
      ip[10] = cs[15:8];
      ip[11] = cs[7:0];
    end
    for (int k = 0; k < hlen; k++) frame_bytes.push_back(ip[k]);
    repeat (f.payload + f.extra) frame_bytes.push_back(8'($urandom));
    if (f.cut > 0) begin
      while (frame_bytes.size() > f.cut) void'(frame_bytes.pop_back());
    end
  endtask

  // one byte item: random gap, then valid held until accepted; ends at a falling edge
  task automatic push_byte(in_item_t it, logic burst);
    int gap;
    gap = burst ? 0 : int'($urandom_range(0, 7));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_byte(it);
    @(negedge clk);
  endtask

  task automatic send_frame(frame_spec_t f, logic burst);
    in_item_t it;
    build_frame(f);
    foreach (frame_bytes[i]) begin
      it.frame_byte = frame_bytes[i];
      it.frame_end = (i == frame_bytes.size() - 1);
      push_byte(it, burst);
    end
  endtask

  // stop sending, let every verdict come back, then cover the pipeline depth
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic program_config(cfg_t c);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_LOCAL_ADDRESS;
    cfg_wdata <= c.local_address;
    @(negedge clk);
    cfg_index <= CFG_SUBNET_MASK;
    cfg_wdata <= c.subnet_mask;
    @(negedge clk);
    cfg_index <= CFG_ZERO_HOST;
    cfg_wdata <= {31'b0, c.zero_host_broadcast};
    @(negedge clk);
    cfg_index <= CFG_ROUTER_MODE;
    cfg_wdata <= {31'b0, c.router_mode};
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_cfg = c;
  endtask

  // destinations spread over every kind of match for the current settings
  function automatic logic [31:0] pick_dest();
    logic [31:0] own;
    logic [31:0] mask;
    logic [31:0] cm;
    own = model_cfg.local_address;
    mask = model_cfg.subnet_mask;
    cm = class_mask(own);
    case ($urandom_range(0, 7))
      0: return own;
      1: return 32'hFFFFFFFF;
      2: return (own & mask) | ~mask;
      3: return own & mask;
      4: return (own & cm) | ~cm;
      5: return own & cm;
      6: return own ^ (32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed packets with random content, the rest broken or noise
  function automatic frame_spec_t random_frame();
    frame_spec_t f;
    int pick;
    int hlen;
    pick = int'($urandom_range(0, 99));
    f.noise = 1'b0;
    f.mcast = ($urandom_range(0, 4) == 0);
    f.ver = 4'd4;
    f.ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    case ($urandom_range(0, 3))
      0: f.flags = 16'h0000;
      1: f.flags = 16'h4000;
      2: f.flags = 16'h2000 | 16'($urandom_range(0, 16'h1FFF));
      default: f.flags = 16'($urandom);
    endcase
    f.proto = 8'($urandom);
    f.src = $urandom;
    f.dst = pick_dest();
    f.payload = int'($urandom_range(0, 8));
    f.extra = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 8)) : 0;
    f.len_adj = 0;
    f.cut = -1;
    f.good_sum = 1'b1;
    hlen = (f.ihl < 4'd5) ? 20 : int'(f.ihl) * 4;
    if (pick >= 70) begin
      case (pick % 6)
        0: f.cut = int'($urandom_range(1, 14 + hlen + f.payload));
        1: f.ver = 4'($urandom);
        2: f.len_adj = int'($urandom_range(0, 35)) - 30;
        3: f.good_sum = 1'b0;
        4: f.ihl = 4'($urandom_range(0, 4));
        default: begin
          f.noise = 1'b1;
          f.cut = int'($urandom_range(1, 80));
        end
      endcase
    end
    return f;
  endfunction

  // result side: random stall per item, stretches without stalls, check on acceptance
  initial begin : result_sink
    int stall;
    out_item_t want;
    out_ready = 1'b0;
    out_burst = 1'b0;
    @(negedge clk);
    forever begin
      stall = out_burst ? 0 : int'($urandom_range(0, 7));
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (pending_verdicts.size() == 0) begin
        report("result item with no frame waiting");
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(out_item.verdict), 32'(want.verdict));
        check_field("header_bytes", 32'(out_item.header_bytes), 32'(want.header_bytes));
        check_field("total_length", 32'(out_item.total_length), 32'(want.total_length));
        check_field("protocol_number", 32'(out_item.protocol_number),
                    32'(want.protocol_number));
        check_field("source_address", out_item.source_address, want.source_address);
        check_field("destination_address", out_item.destination_address,
                    want.destination_address);
        check_field("to_local_address", 32'(out_item.to_local_address),
                    32'(want.to_local_address));
        check_field("has_options", 32'(out_item.has_options), 32'(want.has_options));
      end
      if ($urandom_range(0, 7) == 0) out_burst = ~out_burst;
      @(negedge clk);
    end
  end

  // main sequence: reset, directed frames, then random phases under fresh settings
  initial begin : stimulus
    cfg_t c;
    int cur_set;
    int plen;
    mismatches = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_LOCAL_ADDRESS;
    cfg_wdata = '0;
    model_cfg = '0;
    pin_next = 1'b0;
    pin_verdict = VERDICT_DELIVER;
    cur_set = 0;
    clear_frame_state();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (STEPS[i].cfg_set != cur_set) begin
        program_config(HOME_NET);
        cur_set = STEPS[i].cfg_set;
      end
      pin_next = STEPS[i].pinned;
      pin_verdict = STEPS[i].verdict;
      send_frame(STEPS[i].f, $urandom_range(0, 3) == 0);
    end

    for (int ph = 0; ph < 5; ph++) begin
      plen = int'($urandom_range(0, 32));
      c.local_address = $urandom;
      c.subnet_mask = (plen == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - plen));
      c.zero_host_broadcast = 1'($urandom);
      c.router_mode = 1'($urandom);
      // first two phases pin the settings to their extremes
      if (ph == 0) c = '{32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0};
      if (ph == 1) c = '{32'h0, 32'h0, 1'b1, 1'b1};
      program_config(c);
      repeat (2) send_frame(random_frame(), $urandom_range(0, 3) == 0);
    end

    wait_drain();
    if (mismatches == 0) begin
      $display("[ipv4_receive_header_filter] OK");
    end else begin
      $display("[ipv4_receive_header_filter] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #12000000;
    $display("[ipv4_receive_header_filter] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/irhf_pkg.sv
sv/irhf_parse.sv
sv/irhf_judge.sv
sv/ipv4_receive_header_filter.sv
dv/ipv4_receive_header_filter_test.sv
